@@ rtl/rgba_pixel_blend_modes_unit_defines.svh @@
// Assertion macros for the blend unit checker
`ifndef RGBA_PIXEL_BLEND_MODES_UNIT_DEFINES_SVH
`define RGBA_PIXEL_BLEND_MODES_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on rising edge, off while reset is held
`define RPBM_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, clocked on rising edge, off while reset is held
`define RPBM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

@@ rtl/rpbm_pkg.sv @@
// Types, mode codes and helper functions for the RGBA blend unit
`default_nettype none

package rpbm_pkg;

    // Blend mode codes
    localparam logic [3:0] MODE_AVERAGE  = 4'd0;
    localparam logic [3:0] MODE_ALPHA    = 4'd1;
    localparam logic [3:0] MODE_ADD      = 4'd2;
    localparam logic [3:0] MODE_SUBTRACT = 4'd3;
    localparam logic [3:0] MODE_LIGHTEN  = 4'd4;
    localparam logic [3:0] MODE_DARKEN   = 4'd5;
    localparam logic [3:0] MODE_MULTIPLY = 4'd6;
    localparam logic [3:0] MODE_SCREEN   = 4'd7;
    localparam logic [3:0] MODE_DENSITY  = 4'd8;

    localparam int NUM_CHAN = 3;
    localparam logic [7:0] CHAN_MAX = 8'hFF;

    // Input transaction
    typedef struct packed {
        logic [7:0] base_red;
        logic [7:0] base_green;
        logic [7:0] base_blue;
        logic [7:0] base_alpha;
        logic [7:0] over_red;
        logic [7:0] over_green;
        logic [7:0] over_blue;
        logic [7:0] over_alpha;
    } t_in_pixel;

    // Output transaction
    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } t_out_pixel;

    // Stage 1: products and cheap results, one channel
    typedef struct packed {
        logic [7:0]  base;
        logic [7:0]  over;
        logic [7:0]  simple;
        logic [15:0] p_over_a;
        logic [15:0] p_base_a;
        logic [15:0] p_mul;
        logic [15:0] p_scr;
    } t_s1_chan;

    typedef struct packed {
        logic [3:0]                  mode;
        logic                        take_over;
        logic [7:0]                  alpha;
        t_s1_chan [NUM_CHAN-1:0]     chan;
    } t_s1;

    // Stage 2: quotients by 255, one channel
    typedef struct packed {
        logic [7:0] base;
        logic [7:0] over;
        logic [7:0] simple;
        logic [7:0] q_alpha;
        logic [7:0] q_mul;
        logic [7:0] q_scr;
    } t_s2_chan;

    typedef struct packed {
        logic [3:0]                  mode;
        logic                        take_over;
        logic [7:0]                  alpha;
        t_s2_chan [NUM_CHAN-1:0]     chan;
    } t_s2;

    // floor(x / 255) for x up to 255*255, by reciprocal add and shift
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [15:0] y;
        begin
            // x + x/256 + 1 stays below 2^16 for x up to 255*255
            y = x + {8'd0, x[15:8]} + 16'd1;
            return y[15:8];
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/rgba_pixel_blend_modes_unit.sv @@
// Top level of the RGBA blend unit: mode register and three-stage pipeline
//
//  Channel | Handshake              | Payload
//  --------+------------------------+--------------------------
//  in      | i_in_valid / o_in_stall  | i_in_data  (t_in_pixel)
//  out     | o_out_valid / i_out_stall| o_out_data (t_out_pixel)
//  cfg     | i_cfg_valid / o_cfg_ready| i_cfg_data (blend mode)
//
// One pixel per clock while the output is not stalled; an input transaction passes the
// stage 1, stage 2 and output registers before output valid rises.
// Stages: products and sums, divide by 255 via reciprocal add, mode select.
// The whole pipe holds while the output register is full and stalled; bubbles stay.
// Synchronous active-low reset clears valid bits and sets the blend mode to average.
// The cfg port is always ready.
`default_nettype none

module rgba_pixel_blend_modes_unit
    import rpbm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in_pixel  i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_out_pixel      o_out_data,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [3:0] i_cfg_data
);

    logic [3:0] r_blend_mode;
    logic       en;
    logic       s1_valid;
    t_s1        s1_data;
    logic       s2_valid;
    t_s2        s2_data;

    // Mode register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_mode <= MODE_AVERAGE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_blend_mode <= i_cfg_data;
        end
    end

    // Pipe advances unless a finished transaction waits at the output
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    rpbm_stage_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_mode  (r_blend_mode),
        .o_valid (s1_valid),
        .o_data  (s1_data)
    );

    rpbm_stage_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s1_valid),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .o_data  (s2_data)
    );

    rpbm_stage_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s2_valid),
        .i_data  (s2_data),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

endmodule

`default_nettype wire

@@ rtl/rpbm_stage_mul.sv @@
// Stage 1: channel products, channel sums compare and the add-type blends
`default_nettype none

module rpbm_stage_mul
    import rpbm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic       i_valid,
    input  wire t_in_pixel  i_data,
    input  wire logic [3:0] i_mode,
    output logic            o_valid,
    output t_s1             o_data
);

    logic [7:0] base_c [NUM_CHAN];
    logic [7:0] over_c [NUM_CHAN];
    logic [9:0] sum_base;
    logic [9:0] sum_over;
    t_s1        n_data;
    t_s1        r_data;
    logic       r_valid;

    assign base_c[0] = i_data.base_red;
    assign base_c[1] = i_data.base_green;
    assign base_c[2] = i_data.base_blue;
    assign over_c[0] = i_data.over_red;
    assign over_c[1] = i_data.over_green;
    assign over_c[2] = i_data.over_blue;

    // RGB sums for lighten / darken
    assign sum_base = {2'b0, base_c[0]} + {2'b0, base_c[1]} + {2'b0, base_c[2]};
    assign sum_over = {2'b0, over_c[0]} + {2'b0, over_c[1]} + {2'b0, over_c[2]};

    always_comb begin
        logic [8:0] s;
        logic [7:0] inv_a;
        n_data       = '0;
        n_data.mode  = i_mode;
        n_data.alpha = i_data.base_alpha;
        n_data.take_over = (i_mode == MODE_LIGHTEN) ? (sum_base < sum_over)
                                                    : (sum_base > sum_over);
        inv_a = CHAN_MAX - i_data.over_alpha;
        for (int i = 0; i < NUM_CHAN; i++) begin
            s = {1'b0, base_c[i]} + {1'b0, over_c[i]};
            n_data.chan[i].base     = base_c[i];
            n_data.chan[i].over     = over_c[i];
            n_data.chan[i].p_over_a = {8'd0, over_c[i]} * {8'd0, i_data.over_alpha};
            n_data.chan[i].p_base_a = {8'd0, base_c[i]} * {8'd0, inv_a};
            n_data.chan[i].p_mul    = {8'd0, over_c[i]} * {8'd0, base_c[i]};
            n_data.chan[i].p_scr    = {8'd0, CHAN_MAX - base_c[i]}
                                    * {8'd0, CHAN_MAX - over_c[i]};
            // blends that need no division
            case (i_mode)
                MODE_AVERAGE:  n_data.chan[i].simple = s[8:1];
                MODE_ADD:      n_data.chan[i].simple = s[8] ? CHAN_MAX : s[7:0];
                MODE_SUBTRACT: n_data.chan[i].simple =
                    (base_c[i] > over_c[i]) ? (base_c[i] - over_c[i]) : 8'd0;
                MODE_DENSITY:  n_data.chan[i].simple = s[8] ? (s[7:0] + 8'd1) : 8'd0;
                default:       n_data.chan[i].simple = base_c[i];
            endcase
        end
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

@@ rtl/rpbm_stage_div.sv @@
// Stage 2: divide the channel products by 255
`default_nettype none

module rpbm_stage_div
    import rpbm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_s1  i_data,
    output logic      o_valid,
    output t_s2       o_data
);

    t_s2  n_data;
    t_s2  r_data;
    logic r_valid;

    always_comb begin
        logic [15:0] mix;
        n_data           = '0;
        n_data.mode      = i_data.mode;
        n_data.take_over = i_data.take_over;
        n_data.alpha     = i_data.alpha;
        for (int i = 0; i < NUM_CHAN; i++) begin
            // weighted sum never exceeds 255*255
            mix = i_data.chan[i].p_over_a + i_data.chan[i].p_base_a;
            n_data.chan[i].base    = i_data.chan[i].base;
            n_data.chan[i].over    = i_data.chan[i].over;
            n_data.chan[i].simple  = i_data.chan[i].simple;
            n_data.chan[i].q_alpha = div255(mix);
            n_data.chan[i].q_mul   = div255(i_data.chan[i].p_mul);
            n_data.chan[i].q_scr   = div255(i_data.chan[i].p_scr);
        end
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

@@ rtl/rpbm_stage_out.sv @@
// Stage 3: pick the blend for the mode and hold the output transaction
`default_nettype none

module rpbm_stage_out
    import rpbm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_s2  i_data,
    output logic      o_valid,
    output t_out_pixel o_data
);

    logic [7:0] res [NUM_CHAN];
    t_out_pixel n_data;
    t_out_pixel r_data;
    logic       r_valid;

    // Per-channel result select
    always_comb begin
        for (int i = 0; i < NUM_CHAN; i++) begin
            case (i_data.mode)
                MODE_ALPHA:    res[i] = i_data.chan[i].q_alpha;
                MODE_LIGHTEN,
                MODE_DARKEN:   res[i] = i_data.take_over ? i_data.chan[i].over
                                                         : i_data.chan[i].base;
                MODE_MULTIPLY: res[i] = i_data.chan[i].q_mul;
                MODE_SCREEN:   res[i] = CHAN_MAX - i_data.chan[i].q_scr;
                default:       res[i] = i_data.chan[i].simple;
            endcase
        end
    end

    assign n_data.out_red   = res[0];
    assign n_data.out_green = res[1];
    assign n_data.out_blue  = res[2];
    assign n_data.out_alpha = i_data.alpha;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

@@ rtl/rpbm_checker.sv @@
// Port-level checker for the RGBA blend unit, bound to the top level
`default_nettype none
`include "rgba_pixel_blend_modes_unit_defines.svh"

module rpbm_checker
    import rpbm_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_stall,
    input wire logic [7:0] i_in_base_alpha,
    input wire logic       i_out_valid,
    input wire logic       i_out_stall,
    input wire t_out_pixel i_out_data,
    input wire logic       i_cfg_valid,
    input wire logic       i_cfg_ready
);

    logic in_xact;

    assign in_xact = i_in_valid && !i_in_stall;

    // a held output transaction keeps its data
    `RPBM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall,
        i_out_valid && $stable(i_out_data))

    // input is only stalled behind a stalled output transaction
    `RPBM_ASSERT_NOW(a_in_stall_cause, i_clk, i_rst_n, i_in_stall,
        i_out_valid && i_out_stall)

    // with the pipe moving, a transaction passes stage 1, stage 2 and the output register and shows up
    `RPBM_ASSERT_NEXT(a_latency, i_clk, i_rst_n,
        in_xact ##1 !i_in_stall ##1 !i_in_stall, i_out_valid)

    // the output alpha follows the base alpha through the pipe
    `RPBM_ASSERT_NEXT(a_alpha_pass, i_clk, i_rst_n,
        in_xact ##1 !i_in_stall ##1 !i_in_stall,
        i_out_data.out_alpha == $past(i_in_base_alpha, 3))

    // cfg writes are never refused
    `RPBM_ASSERT_NOW(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, i_cfg_ready)

endmodule

bind rgba_pixel_blend_modes_unit rpbm_checker u_rpbm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .i_in_stall      (o_in_stall),
    .i_in_base_alpha (i_in_data.base_alpha),
    .i_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .i_out_data      (o_out_data),
    .i_cfg_valid     (i_cfg_valid),
    .i_cfg_ready     (o_cfg_ready)
);

`default_nettype wire
